@@ design/msss_pkg.sv @@
// Package for the shared-store multi-stack core: item types, codes and defaults.
// Depends on nothing; the top level imports it.
package msss_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int NUM_STACKS_DEF = 8;
	localparam int CAPACITY_DEF   = 64;

	// Operation codes; the unused code acts as a peek.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_EMPTY   = 2'd3;

	// Value answered on any error.
	localparam logic signed [31:0] ERR_VALUE = -32'sd1;

	// One request item.
	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         stack_number;
		logic signed [31:0] push_value;
	} req_item_t;

	// One response item.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
	} rsp_item_t;

endpackage

@@ design/msss_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the value store and the link store of the multi-stack core.
module msss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/multi_stack_shared_store_core.sv @@
// Top level of the multi-stack core: NUM_STACKS LIFO stacks sharing one store.
// Depends on msss_pkg and on msss_ram for the value and link stores.
//
// NUM_STACKS stacks live as linked lists in one store of CAPACITY slots; free
// slots form a further list. After reset the core threads the free list
// through the link RAM and holds req_stall high while it does so. After that
// each item passes an accept cycle, which reads the link and value RAMs, and
// an execute state, which uses the read data and writes back the link, value
// (on a push), stack head and free head. The next item is taken only after
// the execute state ends, so the core holds one item at a time; a response
// waiting in the output register stalls the core only when a second response
// is ready before the first is taken. Every item gives one response.
module multi_stack_shared_store_core #(
	parameter int NUM_STACKS = msss_pkg::NUM_STACKS_DEF,
	parameter int CAPACITY   = msss_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  msss_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output msss_pkg::rsp_item_t rsp
);
	import msss_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PTR_W  = $clog2(CAPACITY + 1);
	localparam int K_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [PTR_W-1:0]  PTR_NULL  = PTR_W'(CAPACITY);
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);
	localparam logic [4:0]        NS_MAX    = 5'(NUM_STACKS);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] clr_q;
	logic [PTR_W-1:0]  heads_q [NUM_STACKS];
	logic [PTR_W-1:0]  free_head_q;

	// Item registers carried from the accept cycle into the execute cycle.
	logic [1:0]         op_s1;
	logic [K_W-1:0]     k_s1;
	logic               ok_s1;
	logic [PTR_W-1:0]   top_s1;
	logic signed [31:0] pv_s1;

	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	// Request decode in the accept cycle.
	logic               accept;
	logic               sn_ok;
	logic [3:0]         sn_m1;
	logic [K_W-1:0]     k_in;
	logic [PTR_W-1:0]   top_in;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign sn_ok     = (req.stack_number != 4'd0) && ({1'b0, req.stack_number} <= NS_MAX);
	assign sn_m1     = req.stack_number - 4'd1;
	assign k_in      = sn_m1[K_W-1:0];
	assign top_in    = sn_ok ? heads_q[k_in] : PTR_NULL;

	// Memory ports.
	logic               link_we;
	logic [ADDR_W-1:0]  link_waddr;
	logic [PTR_W-1:0]   link_wdata;
	logic [ADDR_W-1:0]  link_raddr;
	logic [PTR_W-1:0]   link_rdata;
	logic               val_we;
	logic [31:0]        val_rdata;

	// A push reads the link of the free head, a pop the link of the top slot.
	assign link_raddr = (req.op == OP_PUSH) ? free_head_q[ADDR_W-1:0] : top_in[ADDR_W-1:0];

	msss_ram #(
		.WIDTH(PTR_W),
		.DEPTH(CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	msss_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (free_head_q[ADDR_W-1:0]),
		.wdata (pv_s1),
		.re    (accept),
		.raddr (top_in[ADDR_W-1:0]),
		.rdata (val_rdata)
	);

	// Execute stage: classify the item and form the response.
	logic       rsp_free;
	logic       exec_fire;
	logic       is_push;
	logic       is_pop;
	logic       top_null;
	logic       free_null;
	logic       do_push;
	logic       do_pop;
	rsp_item_t  rsp_d;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign exec_fire = (state_q == S_EXEC) && rsp_free;
	assign is_push   = (op_s1 == OP_PUSH);
	assign is_pop    = (op_s1 == OP_POP);
	assign top_null  = (top_s1 >= PTR_NULL);
	assign free_null = (free_head_q >= PTR_NULL);
	assign do_push   = ok_s1 && is_push && !free_null;
	assign do_pop    = ok_s1 && is_pop && !top_null;

	always_comb begin
		rsp_d.status     = STAT_OK;
		rsp_d.read_value = ERR_VALUE;
		if (!ok_s1) begin
			rsp_d.status = STAT_INVALID;
		end else if (is_push) begin
			if (free_null) begin
				rsp_d.status = STAT_FULL;
			end else begin
				rsp_d.read_value = 32'sd0;
			end
		end else if (top_null) begin
			rsp_d.status = STAT_EMPTY;
		end else begin
			rsp_d.read_value = val_rdata;
		end
	end

	// Link write: threading pass after reset, then push and pop write-back.
	always_comb begin
		link_we    = 1'b0;
		link_waddr = clr_q;
		link_wdata = PTR_W'(clr_q) + PTR_W'(1);
		if (state_q == S_CLEAR) begin
			link_we = 1'b1;
		end else if (exec_fire && do_push) begin
			link_we    = 1'b1;
			link_waddr = free_head_q[ADDR_W-1:0];
			link_wdata = top_s1;
		end else if (exec_fire && do_pop) begin
			link_we    = 1'b1;
			link_waddr = top_s1[ADDR_W-1:0];
			link_wdata = free_head_q;
		end
	end

	assign val_we = exec_fire && do_push;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Item capture in the accept cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= req.op;
			k_s1   <= k_in;
			ok_s1  <= sn_ok;
			top_s1 <= top_in;
			pv_s1  <= req.push_value;
		end
	end

	// Stack heads and free head update on write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			for (int i = 0; i < NUM_STACKS; i++) begin
				heads_q[i] <= PTR_NULL;
			end
		end else if (exec_fire) begin
			if (do_push) begin
				heads_q[k_s1] <= free_head_q;
				free_head_q   <= (link_rdata >= PTR_NULL) ? PTR_NULL : link_rdata;
			end else if (do_pop) begin
				heads_q[k_s1] <= (link_rdata >= PTR_NULL) ? PTR_NULL : link_rdata;
				free_head_q   <= top_s1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
